// ===== hdl/ttle_pkg.sv =====
// ttle_pkg: shared constants, register codes and saturation helpers for the
// tapered tube law evaluator; used by every file under hdl
`timescale 1ns / 1ps

package ttle_pkg;

    // pipeline depths
    localparam int SQ_LAT = 29;
    localparam int MD_LAT = 66;
    localparam int N_STG  = SQ_LAT + 3 * MD_LAT + 5;

    // register indexes, paddr[5:3]
    localparam logic [2:0] REG_AREA_INLET   = 3'd0;
    localparam logic [2:0] REG_AREA_OUTLET  = 3'd1;
    localparam logic [2:0] REG_SEG_LENGTH   = 3'd2;
    localparam logic [2:0] REG_WALL_STIFF   = 3'd3;
    localparam logic [2:0] REG_REF_PRESSURE = 3'd4;

    localparam logic [31:0] RST_AREA   = 32'h0100_0000;
    localparam logic [31:0] RST_LENGTH = 32'h0100_0000;
    localparam logic [46:0] RST_STIFF  = 47'h1_0000;

    localparam logic [63:0] MAX_POS48 = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] MIN_MAG48 = 64'h0000_8000_0000_0000;

    // ceil(2^51 / 3) as low 32 and high 18 bits: exact one third of any 50-bit value
    localparam logic [31:0] DIV3_LO = 32'hAAAA_AAAB;
    localparam logic [17:0] DIV3_HI = 18'h2_AAAA;

    // sign and magnitude to saturated 48-bit two's complement
    function automatic logic [47:0] out_signed(input logic neg, input logic [63:0] mag);
        logic [47:0] m;
        if (neg) begin
            m = (mag > MIN_MAG48) ? MIN_MAG48[47:0] : mag[47:0];
            return 48'(~m + 48'd1);
        end
        return (mag > MAX_POS48) ? MAX_POS48[47:0] : mag[47:0];
    endfunction

    // clamp a signed 51-bit value to 48 bits
    function automatic logic [47:0] sat_pressure(input logic signed [50:0] v);
        if (v > 51'sh0_7FFF_FFFF_FFFF)
            return 48'h7FFF_FFFF_FFFF;
        if (v < -51'sh0_8000_0000_0000)
            return 48'h8000_0000_0000;
        return v[47:0];
    endfunction

endpackage

// ===== hdl/ttle_isqrt.sv =====
// ttle_isqrt: pipelined integer square root of a 56-bit radicand, one result
// bit per stage; depends on ttle_pkg for its depth
`timescale 1ns / 1ps

module ttle_isqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [55:0] rad,
    output logic [27:0] root
);

    typedef struct packed {
        logic [29:0] rem;
        logic [27:0] root;
    } sq_t;

    logic [55:0] rad_reg  [ttle_pkg::SQ_LAT];
    logic [29:0] rem_reg  [ttle_pkg::SQ_LAT];
    logic [27:0] root_reg [ttle_pkg::SQ_LAT];

    function automatic sq_t sq_step(input logic [29:0] rem, input logic [27:0] rt,
                                    input logic [1:0] pair);
        logic [31:0] t;
        logic [31:0] trial;
        logic [31:0] diff;
        sq_t r;
        t     = {rem, pair};
        trial = {2'b00, rt, 2'b01};
        diff  = t - trial;
        if (t >= trial) begin
            r.rem  = diff[29:0];
            r.root = {rt[26:0], 1'b1};
        end else begin
            r.rem  = t[29:0];
            r.root = {rt[26:0], 1'b0};
        end
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg[0]  <= rad;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            for (int j = 1; j < ttle_pkg::SQ_LAT; j++)
            begin
                sq_t s;
                s = sq_step(rem_reg[j-1], root_reg[j-1], rad_reg[j-1][55:54]);
                rad_reg[j]  <= {rad_reg[j-1][53:0], 2'b00};
                rem_reg[j]  <= s.rem;
                root_reg[j] <= s.root;
            end
        end
    end

    assign root = root_reg[ttle_pkg::SQ_LAT-1];

endmodule

// ===== hdl/ttle_muldiv.sv =====
// ttle_muldiv: pipelined floor(a*b/c) with a 128-bit product, saturating at
// all ones; partial products, a sum stage, then one quotient bit per stage
`timescale 1ns / 1ps

module ttle_muldiv (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] num_a,
    input  logic [63:0] num_b,
    input  logic [63:0] den,
    output logic [63:0] quo
);

    localparam int NDIV = ttle_pkg::MD_LAT - 1;

    logic [63:0] pp00_reg, pp01_reg, pp10_reg, pp11_reg, den0_reg;
    logic [127:0] prod;

    logic [63:0] rem_reg [NDIV];
    logic [63:0] lo_reg  [NDIV];
    logic [63:0] q_reg   [NDIV];
    logic [63:0] den_reg [NDIV];
    logic        sat_reg [NDIV];

    assign prod = {64'd0, pp00_reg} + {32'd0, pp01_reg, 32'd0}
                + {32'd0, pp10_reg, 32'd0} + {pp11_reg, 64'd0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp00_reg <= 64'(num_a[31:0])  * 64'(num_b[31:0]);
            pp01_reg <= 64'(num_a[31:0])  * 64'(num_b[63:32]);
            pp10_reg <= 64'(num_a[63:32]) * 64'(num_b[31:0]);
            pp11_reg <= 64'(num_a[63:32]) * 64'(num_b[63:32]);
            den0_reg <= den;

            rem_reg[0] <= prod[127:64];
            lo_reg[0]  <= prod[63:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den0_reg;
            sat_reg[0] <= (den0_reg == 64'd0) || (prod[127:64] >= den0_reg);

            for (int j = 1; j < NDIV; j++)
            begin
                logic [64:0] t;
                logic [64:0] d;
                logic        ge;
                t  = {rem_reg[j-1], lo_reg[j-1][63]};
                ge = t >= {1'b0, den_reg[j-1]};
                d  = t - {1'b0, den_reg[j-1]};
                rem_reg[j] <= ge ? d[63:0] : t[63:0];
                lo_reg[j]  <= {lo_reg[j-1][62:0], 1'b0};
                q_reg[j]   <= {q_reg[j-1][62:0], ge};
                den_reg[j] <= den_reg[j-1];
                sat_reg[j] <= sat_reg[j-1];
            end
        end
    end

    assign quo = sat_reg[NDIV-1] ? '1 : q_reg[NDIV-1];

endmodule

// ===== hdl/tapered_tube_law_evaluator.sv =====
// tapered_tube_law_evaluator: top level, configuration registers and the
// evaluation pipeline; uses ttle_pkg, ttle_isqrt and ttle_muldiv
`timescale 1ns / 1ps

// Use: write the five registers over the APB port (8-byte stride, 64-bit data,
// pready always high) while no transaction is in flight, then stream items on
// the in_valid/in_ready channel. Each item gives exactly one result on the
// out_valid/out_ready channel, in order.
// Throughput: one transaction per cycle while the receiver takes results.
// Structure: a 29-stage square root from acceptance, then three chained 66-stage
// multiply-divide units for the taper step, the main quotients and the
// derivative/integral quotients, plus five glue stages up to out_valid.
// The integral's divide by a constant is a reciprocal multiply padded to the
// same 66-stage depth.
// The pipeline moves as one: when out_valid is high and out_ready is low every
// stage holds and in_ready drops, so nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults (areas 1.0,
// length 1.0, stiffness 1.0, reference pressure 0). No clearing pass is needed.
module tapered_tube_law_evaluator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        area_in,
    input  logic signed [47:0] pressure_in,
    input  logic [31:0]        position,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [47:0] pressure_from_area,
    output logic [31:0]        area_from_pressure,
    output logic signed [47:0] slope_p_area,
    output logic signed [47:0] slope_p_axial,
    output logic signed [47:0] pressure_integral,
    output logic               error_flag
);

    localparam int N  = ttle_pkg::N_STG;
    localparam int SQ = ttle_pkg::SQ_LAT;
    localparam int MD = ttle_pkg::MD_LAT;

    typedef struct packed {
        logic [31:0] a;
        logic [47:0] p;
        logic [31:0] z;
    } sq_side_t;

    typedef struct packed {
        logic [31:0] a;
        logic [47:0] p;
        logic [27:0] sa;
        logic [27:0] gi;
        logic        dneg;
        logic        dpos;
        logic [27:0] adiff;
        logic        err;
    } b_side_t;

    typedef struct packed {
        logic        w1neg;
        logic        dpos;
        logic [61:0] mm;
        logic        err;
    } c_side_t;

    typedef struct packed {
        logic [47:0] out0;
        logic [31:0] out1;
        logic [47:0] out2;
        logic        dneg;
        logic        dpos;
        logic        err;
    } d_side_t;

    // configuration
    logic [31:0] area_inlet_reg, area_outlet_reg, segment_length_reg;
    logic [46:0] wall_stiffness_reg;
    logic [47:0] reference_pressure_reg;
    logic [63:0] e64, len64;
    logic signed [50:0] p1_ext;

    assign pready = 1'b1;
    assign e64    = {17'd0, wall_stiffness_reg};
    assign len64  = {32'd0, segment_length_reg};
    assign p1_ext = 51'(signed'(reference_pressure_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_inlet_reg         <= ttle_pkg::RST_AREA;
            area_outlet_reg        <= ttle_pkg::RST_AREA;
            segment_length_reg     <= ttle_pkg::RST_LENGTH;
            wall_stiffness_reg     <= ttle_pkg::RST_STIFF;
            reference_pressure_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[5:3])
                ttle_pkg::REG_AREA_INLET:   area_inlet_reg         <= pwdata[31:0];
                ttle_pkg::REG_AREA_OUTLET:  area_outlet_reg        <= pwdata[31:0];
                ttle_pkg::REG_SEG_LENGTH:   segment_length_reg     <= pwdata[31:0];
                ttle_pkg::REG_WALL_STIFF:   wall_stiffness_reg     <= pwdata[46:0];
                ttle_pkg::REG_REF_PRESSURE: reference_pressure_reg <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[5:3])
            ttle_pkg::REG_AREA_INLET:   prdata = {32'd0, area_inlet_reg};
            ttle_pkg::REG_AREA_OUTLET:  prdata = {32'd0, area_outlet_reg};
            ttle_pkg::REG_SEG_LENGTH:   prdata = {32'd0, segment_length_reg};
            ttle_pkg::REG_WALL_STIFF:   prdata = {17'd0, wall_stiffness_reg};
            ttle_pkg::REG_REF_PRESSURE: prdata = {16'd0, reference_pressure_reg};
            default:                    prdata = '0;
        endcase
    end

    // pipeline control
    logic [N-1:0] vld_reg;
    logic         adv;

    assign adv       = !vld_reg[N-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[N-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[N-2:0], in_valid};
    end

    // square roots of the current area and both end areas
    logic [27:0] sa_root, gi_root, go_root;
    sq_side_t    sq_dl_reg [SQ];

    ttle_isqrt u_sq_a (.clk(clk), .en(adv), .rad({area_in, 24'd0}),         .root(sa_root));
    ttle_isqrt u_sq_i (.clk(clk), .en(adv), .rad({area_inlet_reg, 24'd0}),  .root(gi_root));
    ttle_isqrt u_sq_o (.clk(clk), .en(adv), .rad({area_outlet_reg, 24'd0}), .root(go_root));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_dl_reg[0] <= '{a: area_in, p: pressure_in, z: position};
            for (int i = 1; i < SQ; i++)
                sq_dl_reg[i] <= sq_dl_reg[i-1];
        end
    end

    // taper difference
    sq_side_t     sq_out;
    logic [31:0]  p1_z_reg;
    b_side_t      p1_reg, p1_next;
    logic signed [28:0] diff;

    assign sq_out = sq_dl_reg[SQ-1];
    assign diff   = signed'({1'b0, go_root}) - signed'({1'b0, gi_root});

    always_comb
    begin
        p1_next.a     = sq_out.a;
        p1_next.p     = sq_out.p;
        p1_next.sa    = sa_root;
        p1_next.gi    = gi_root;
        p1_next.dneg  = diff[28];
        p1_next.dpos  = !diff[28] && (diff != 29'sd0);
        p1_next.adiff = diff[28] ? 28'(-diff) : diff[27:0];
        p1_next.err   = (sq_out.a == 32'd0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg   <= p1_next;
            p1_z_reg <= sq_out.z;
        end
    end

    // taper step along the axis
    logic [63:0] step_q;
    b_side_t     b_dl_reg [MD];

    ttle_muldiv u_md_step (.clk(clk), .en(adv), .num_a({36'd0, p1_reg.adiff}),
                           .num_b({32'd0, p1_z_reg}), .den(len64), .quo(step_q));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_dl_reg[0] <= p1_reg;
            for (int i = 1; i < MD; i++)
                b_dl_reg[i] <= b_dl_reg[i-1];
        end
    end

    // local reference root
    b_side_t     b_out;
    logic [40:0] step_c;
    logic signed [42:0] g;
    logic [41:0] g_mag;
    logic [30:0] m_next;

    b_side_t     p2_reg, p2_next;
    logic [30:0] p2_m_reg;

    assign b_out  = b_dl_reg[MD-1];
    assign step_c = (step_q > 64'h100_0000_0000) ? 41'h100_0000_0000 : step_q[40:0];
    assign g      = b_out.dneg ? signed'({15'd0, b_out.gi}) - signed'({2'd0, step_c})
                               : signed'({15'd0, b_out.gi}) + signed'({2'd0, step_c});
    assign g_mag  = g[42] ? 42'(-g) : g[41:0];
    assign m_next = (g_mag > 42'h7FFF_FFFF) ? 31'h7FFF_FFFF : g_mag[30:0];

    always_comb
    begin
        p2_next     = b_out;
        p2_next.err = b_out.err || (m_next == 31'd0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_reg   <= p2_next;
            p2_m_reg <= m_next;
        end
    end

    // products and operands for the main quotients
    logic signed [32:0] w1;
    logic signed [49:0] w2;

    logic [31:0] p3_a_reg;
    logic [27:0] p3_sa_reg;
    logic [30:0] p3_m_reg;
    logic [58:0] p3_msa_reg;
    logic [55:0] p3_asa_reg;
    logic [31:0] p3_w1mag_reg;
    logic [49:0] p3_w2mag_reg;
    c_side_t     p3_side_reg;

    assign w1 = signed'({5'd0, p2_reg.sa}) - signed'({2'd0, p2_m_reg});
    assign w2 = signed'({3'd0, wall_stiffness_reg}) + 50'(signed'(p2_reg.p))
              - 50'(signed'(reference_pressure_reg));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p3_a_reg     <= p2_reg.a;
            p3_sa_reg    <= p2_reg.sa;
            p3_m_reg     <= p2_m_reg;
            p3_msa_reg   <= 59'(p2_m_reg) * 59'(p2_reg.sa);
            p3_asa_reg   <= 56'(p2_reg.adiff) * 56'(p2_reg.sa);
            p3_w1mag_reg <= w1[32] ? 32'(-w1) : w1[31:0];
            p3_w2mag_reg <= w2[49] ? 50'(-w2) : w2;
            p3_side_reg  <= '{w1neg: w1[32], dpos: p2_reg.dpos,
                              mm: 62'(p2_m_reg) * 62'(p2_m_reg), err: p2_reg.err};
        end
    end

    logic [63:0] m64;
    logic [63:0] delta_q, u_q, dpa_q, t1_q, x_q;
    c_side_t     c_dl_reg [MD];

    assign m64 = {33'd0, p3_m_reg};

    ttle_muldiv u_md_delta (.clk(clk), .en(adv), .num_a(e64),
                            .num_b({32'd0, p3_w1mag_reg}), .den(m64), .quo(delta_q));
    ttle_muldiv u_md_area  (.clk(clk), .en(adv), .num_a(m64),
                            .num_b({14'd0, p3_w2mag_reg}), .den(e64), .quo(u_q));
    ttle_muldiv u_md_dpa   (.clk(clk), .en(adv), .num_a(e64),
                            .num_b(64'h0000_8000_0000_0000),
                            .den({5'd0, p3_msa_reg}), .quo(dpa_q));
    ttle_muldiv u_md_t1    (.clk(clk), .en(adv), .num_a(e64), .num_b({8'd0, p3_asa_reg}),
                            .den({2'd0, p3_side_reg.mm}), .quo(t1_q));
    ttle_muldiv u_md_x     (.clk(clk), .en(adv), .num_a({32'd0, p3_a_reg}),
                            .num_b({36'd0, p3_sa_reg}), .den(m64), .quo(x_q));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_dl_reg[0] <= p3_side_reg;
            for (int i = 1; i < MD; i++)
                c_dl_reg[i] <= c_dl_reg[i-1];
        end
    end

    // pressure, area and dp/dA results; integral difference
    c_side_t     c_out;
    logic [49:0] delta_c;
    logic signed [50:0] v;
    logic [63:0] uu;
    logic [39:0] uu_s;
    logic signed [64:0] d;

    d_side_t     p4_reg;
    logic [63:0] p4_t1_reg, p4_dmag_reg;

    assign c_out   = c_dl_reg[MD-1];
    assign delta_c = (delta_q > 64'h2_0000_0000_0000) ? 50'h2_0000_0000_0000 : delta_q[49:0];
    assign v       = c_out.w1neg ? p1_ext - signed'({1'b0, delta_c})
                                 : p1_ext + signed'({1'b0, delta_c});
    assign uu      = 64'(u_q[31:0]) * 64'(u_q[31:0]);
    assign uu_s    = uu[63:24];
    assign d       = signed'({1'b0, x_q}) - signed'({27'd0, c_out.mm[61:24]});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p4_reg.out0 <= ttle_pkg::sat_pressure(v);
            p4_reg.out1 <= ((u_q[63:32] != 32'd0) || (uu_s[39:32] != 8'd0)) ? '1 : uu_s[31:0];
            p4_reg.out2 <= ttle_pkg::out_signed(1'b0, dpa_q);
            p4_reg.dneg <= d[64];
            p4_reg.dpos <= c_out.dpos;
            p4_reg.err  <= c_out.err;
            p4_t1_reg   <= t1_q;
            p4_dmag_reg <= d[64] ? 64'(-d) : d[63:0];
        end
    end

    // axial slope and integral quotients
    logic [63:0] t2_q, it_q;
    d_side_t     d_dl_reg [MD];
    d_side_t     d_out;
    logic        err_all;

    logic [63:0]  it_pp00_reg, it_pp01_reg, it_pp10_reg, it_pp11_reg;
    logic [127:0] it_prod;
    logic         it_sat_reg, it_sat3_reg;
    logic [49:0]  it_q50_reg;
    logic [63:0]  it_r00_reg, it_r01_reg, it_r10_reg, it_r11_reg;
    logic [127:0] it_rsum;
    logic [63:0]  it_quo_reg;
    logic [63:0]  it_dl_reg [MD-4];

    ttle_muldiv u_md_t2 (.clk(clk), .en(adv), .num_a(p4_t1_reg),
                         .num_b(64'h0000_0000_0100_0000), .den(len64), .quo(t2_q));

    // integral: floor(e*|d| / 2^24) times one third; beyond 2^50 it saturates anyway
    assign it_prod = {64'd0, it_pp00_reg} + {32'd0, it_pp01_reg, 32'd0}
                   + {32'd0, it_pp10_reg, 32'd0} + {it_pp11_reg, 64'd0};
    assign it_rsum = {64'd0, it_r00_reg} + {32'd0, it_r01_reg, 32'd0}
                   + {32'd0, it_r10_reg, 32'd0} + {it_r11_reg, 64'd0};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it_pp00_reg <= 64'(e64[31:0])  * 64'(p4_dmag_reg[31:0]);
            it_pp01_reg <= 64'(e64[31:0])  * 64'(p4_dmag_reg[63:32]);
            it_pp10_reg <= 64'(e64[63:32]) * 64'(p4_dmag_reg[31:0]);
            it_pp11_reg <= 64'(e64[63:32]) * 64'(p4_dmag_reg[63:32]);

            it_sat_reg  <= (it_prod[127:74] != 54'd0);
            it_q50_reg  <= it_prod[73:24];

            it_r00_reg  <= 64'(it_q50_reg[31:0])  * 64'(ttle_pkg::DIV3_LO);
            it_r01_reg  <= 64'(it_q50_reg[31:0])  * 64'(ttle_pkg::DIV3_HI);
            it_r10_reg  <= 64'(it_q50_reg[49:32]) * 64'(ttle_pkg::DIV3_LO);
            it_r11_reg  <= 64'(it_q50_reg[49:32]) * 64'(ttle_pkg::DIV3_HI);
            it_sat3_reg <= it_sat_reg;

            it_quo_reg  <= it_sat3_reg ? '1 : {15'd0, it_rsum[99:51]};

            it_dl_reg[0] <= it_quo_reg;
            for (int i = 1; i < MD - 4; i++)
                it_dl_reg[i] <= it_dl_reg[i-1];
        end
    end

    assign it_q = it_dl_reg[MD-5];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_dl_reg[0] <= p4_reg;
            for (int i = 1; i < MD; i++)
                d_dl_reg[i] <= d_dl_reg[i-1];
        end
    end

    assign d_out   = d_dl_reg[MD-1];
    assign err_all = d_out.err || (segment_length_reg == 32'd0) || (wall_stiffness_reg == 47'd0);

    // output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (err_all)
            begin
                pressure_from_area <= '0;
                area_from_pressure <= '0;
                slope_p_area       <= '0;
                slope_p_axial      <= '0;
                pressure_integral  <= '0;
                error_flag         <= 1'b1;
            end
            else
            begin
                pressure_from_area <= d_out.out0;
                area_from_pressure <= d_out.out1;
                slope_p_area       <= d_out.out2;
                slope_p_axial      <= ttle_pkg::out_signed(d_out.dpos, t2_q);
                pressure_integral  <= ttle_pkg::out_signed(d_out.dneg, it_q);
                error_flag         <= 1'b0;
            end
        end
    end

endmodule
